### hdl/dtb_pkg.sv
`timescale 1ns / 1ps

package dtb_pkg;

    // fixed widths of the stream fields
    localparam int unsigned IN_COORD_W  = 32;
    localparam int unsigned OUT_COORD_W = 32;
    localparam int unsigned IDX_OUT_W   = 6;
    localparam int unsigned HELD_OUT_W  = 7;
    localparam int unsigned STRIDE_W    = 5;
    localparam int unsigned CTR_W       = 32;

    // x, y, z on the input side
    localparam int unsigned S_TDATA_W = 3 * IN_COORD_W;
    // x, y, z, entry_index, entries_held, stride_exponent, padded to bytes
    localparam int unsigned M_USED_W  = 3 * OUT_COORD_W + IDX_OUT_W + HELD_OUT_W + STRIDE_W;
    localparam int unsigned M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int unsigned M_PAD_W   = M_TDATA_W - M_USED_W;

    localparam logic [STRIDE_W-1:0] STRIDE_LOG_MAX = 5'd31;

    // input kind carried on s_tuser
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;      // latch the incoming point
        logic ctr_inc;      // advance the push counter
        logic store_write;  // append held point at the current count
        logic idx_clr;
        logic idx_inc;
        logic rd_issue;     // readout memory read at idx
        logic thin_step;    // read entry 2*idx, write entry idx-1
        logic thin_done;    // halve count, bump stride
        logic out_load;     // fill the output register
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic take;         // push counter is a multiple of the stride
        logic full;
        logic thin_last;
        logic rd_last;
        logic out_free;
    } dp_status_t;

endpackage

### hdl/dtb_datapath.sv
`timescale 1ns / 1ps

module dtb_datapath #(
    parameter int unsigned MAX_POINTS = 64,
    parameter int unsigned COORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dtb_pkg::ctl_cmd_t               cmd,
    output dtb_pkg::dp_status_t             status,
    input  logic [dtb_pkg::S_TDATA_W-1:0]   in_tdata,
    output logic [dtb_pkg::M_TDATA_W-1:0]   out_tdata,
    output logic                            out_tvalid,
    input  logic                            out_tready,
    output logic                            out_tlast,
    output logic                            out_tuser
);

    localparam int unsigned AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
    localparam int unsigned HALF = MAX_POINTS / 2;
    localparam int unsigned DW   = 3 * COORD_BITS;
    localparam int unsigned ICW  = dtb_pkg::IN_COORD_W;
    localparam int unsigned OCW  = dtb_pkg::OUT_COORD_W;

    logic [DW-1:0]                      mem [MAX_POINTS];
    logic [DW-1:0]                      q_reg;
    logic [DW-1:0]                      hold_reg;

    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      idx_reg;
    logic [dtb_pkg::STRIDE_W-1:0]       stride_reg;
    logic [dtb_pkg::CTR_W-1:0]          ctr_reg;
    logic                               out_valid_reg;

    logic [OCW-1:0]                     ox_reg;
    logic [OCW-1:0]                     oy_reg;
    logic [OCW-1:0]                     oz_reg;
    logic [dtb_pkg::IDX_OUT_W-1:0]      oidx_reg;
    logic [dtb_pkg::HELD_OUT_W-1:0]     oheld_reg;
    logic [dtb_pkg::STRIDE_W-1:0]       ostride_reg;
    logic                               olast_reg;
    logic                               oempty_reg;

    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic [DW-1:0]                      wr_data;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic [dtb_pkg::CTR_W-1:0]          stride_mask;
    logic                               empty;

    // memory port selection
    assign wr_en   = cmd.store_write || (cmd.thin_step && (idx_reg != '0));
    assign wr_addr = cmd.store_write ? count_reg[AW-1:0] : AW'(idx_reg - CW'(1));
    // append writes the held point, thinning moves the entry read the cycle before
    assign wr_data = cmd.store_write ? hold_reg : q_reg;
    assign rd_en   = cmd.rd_issue || cmd.thin_step;
    assign rd_addr = cmd.thin_step ? AW'({idx_reg, 1'b0}) : idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // status
    assign stride_mask      = ~({dtb_pkg::CTR_W{1'b1}} << stride_reg);
    assign empty            = (count_reg == '0);
    assign status.take      = ((ctr_reg & stride_mask) == '0);
    assign status.full      = (count_reg == CW'(MAX_POINTS));
    assign status.thin_last = (idx_reg == CW'(HALF));
    assign status.rd_last   = empty || ((idx_reg + CW'(1)) == count_reg);
    assign status.out_free  = !out_valid_reg || out_tready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            stride_reg    <= '0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ctr_inc)
            begin
                ctr_reg <= ctr_reg + dtb_pkg::CTR_W'(1);
            end
            if (cmd.store_write)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.thin_done)
            begin
                count_reg <= CW'(HALF);
            end
            if (cmd.thin_done && (stride_reg != dtb_pkg::STRIDE_LOG_MAX))
            begin
                stride_reg <= stride_reg + dtb_pkg::STRIDE_W'(1);
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc || cmd.thin_step)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hold_reg <= {COORD_BITS'(in_tdata[3*ICW-1:2*ICW]),
                         COORD_BITS'(in_tdata[2*ICW-1:ICW]),
                         COORD_BITS'(in_tdata[ICW-1:0])};
        end
        if (cmd.out_load)
        begin
            ox_reg      <= empty ? '0 : OCW'(q_reg[COORD_BITS-1:0]);
            oy_reg      <= empty ? '0 : OCW'(q_reg[2*COORD_BITS-1:COORD_BITS]);
            oz_reg      <= empty ? '0 : OCW'(q_reg[DW-1:2*COORD_BITS]);
            oidx_reg    <= dtb_pkg::IDX_OUT_W'(idx_reg);
            oheld_reg   <= dtb_pkg::HELD_OUT_W'(count_reg);
            ostride_reg <= stride_reg;
            olast_reg   <= status.rd_last;
            oempty_reg  <= empty;
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tlast  = olast_reg;
    assign out_tuser  = oempty_reg;
    assign out_tdata  = {{dtb_pkg::M_PAD_W{1'b0}}, ostride_reg, oheld_reg, oidx_reg,
                         oz_reg, oy_reg, ox_reg};

endmodule

### hdl/dtb_controller.sv
`timescale 1ns / 1ps

module dtb_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_tvalid,
    input  logic                 in_tuser,
    output logic                 in_tready,
    input  dtb_pkg::dp_status_t  status,
    output dtb_pkg::ctl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_THIN,
        S_APPEND,
        S_RD_REQ,
        S_RD_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;

    assign accept    = in_tvalid && ready_reg;
    assign in_tready = ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    if (in_tuser == dtb_pkg::MODE_READ)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_RD_REQ;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                cmd.ctr_inc = 1'b1;
                state_next  = S_IDLE;
                if (status.take && status.full)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_THIN;
                end
                else if (status.take)
                begin
                    cmd.store_write = 1'b1;
                end
            end
            S_THIN:
            begin
                cmd.thin_step = 1'b1;
                if (status.thin_last)
                begin
                    cmd.thin_done = 1'b1;
                    state_next    = S_APPEND;
                end
            end
            S_APPEND:
            begin
                cmd.store_write = 1'b1;
                state_next      = S_IDLE;
            end
            S_RD_REQ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_LOAD;
            end
            S_RD_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD_REQ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

endmodule

### hdl/decimating_trail_buffer.sv
`timescale 1ns / 1ps

// channel   dir  handshake          tdata                                 tuser          tlast
// s_axis    in   s_tvalid/s_tready  x, y, z (96 bits)                     mode           -
// m_axis    out  m_tvalid/m_tready  x, y, z, index, held, stride (120)    trail_empty    last_entry
//
// a push is accepted in S_IDLE, then S_PUSH does the stride check and store write
// a push that the stride check takes while the trail is full runs a thinning pass first;
// it copies one entry per cycle through the single read and write port of the point memory
// a readout is accepted, then each entry passes S_RD_REQ and S_RD_LOAD, waiting while m_tready stalls
// reset clears count, stride and push counter at once; the point memory is not cleared
// one transfer is worked on at a time; s_tready is low until it is finished

module decimating_trail_buffer #(
    parameter int unsigned MAX_POINTS = 64,
    parameter int unsigned COORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dtb_pkg::S_TDATA_W-1:0]   s_tdata,  // point_x, point_y, point_z
    input  logic                            s_tuser,  // mode: 0 push, 1 read out
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x, out_y, out_z, entry_index, entries_held, stride_exponent, zero pad
    output logic [dtb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,  // trail_empty
    output logic                            m_tlast   // last_entry
);

    dtb_pkg::ctl_cmd_t   cmd;
    dtb_pkg::dp_status_t status;

    // sequencing of push, thinning and readout
    dtb_controller u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_tvalid),
        .in_tuser  (s_tuser),
        .in_tready (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // point memory, counters and output register
    dtb_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_tdata   (s_tdata),
        .out_tdata  (m_tdata),
        .out_tvalid (m_tvalid),
        .out_tready (m_tready),
        .out_tlast  (m_tlast),
        .out_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // one item at a time: ready drops right after an accepted transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while previous item still in work");

    // an empty readout is a single result with zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[108:102] == 7'd0)))
    else $error("empty readout not marked last or count nonzero");

    // the last entry of a readout sits at index count - 1
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && !m_tuser) |->
        (m_tdata[101:96] == 6'(m_tdata[108:102] - 7'd1)))
    else $error("last entry index does not match entry count");
`endif

endmodule
